/* rtl/wavhp_pkg.sv */
// wavhp_pkg: parse phases, status codes, RIFF tags and the result record
// of the WAV header parser. No dependencies; used by every file but wavhp_if.
package wavhp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_SIZE      = 4'd1,
    PH_WAVE      = 4'd2,
    PH_CK_ID     = 4'd3,
    PH_CK_LEN    = 4'd4,
    PH_CK_SKIP   = 4'd5,
    PH_FMT_CODE  = 4'd6,
    PH_FMT_CHAN  = 4'd7,
    PH_FMT_RATE  = 4'd8,
    PH_FMT_BRATE = 4'd9,
    PH_FMT_ALIGN = 4'd10,
    PH_FMT_BITS  = 4'd11,
    PH_DS_SKIP   = 4'd12,
    PH_DS_ID     = 4'd13,
    PH_DS_LEN    = 4'd14
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NO_RIFF    = 4'd1,
    ST_NO_WAVE    = 4'd2,
    ST_NO_FMT     = 4'd3,
    ST_ZERO_CHUNK = 4'd4,
    ST_NOT_PCM    = 4'd5,
    ST_CHANNELS   = 4'd6,
    ST_BITS       = 4'd7,
    ST_NO_DATA    = 4'd8,
    ST_EMPTY_DATA = 4'd9
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] CHAN_MONO    = 16'd1;
  localparam logic [15:0] CHAN_STEREO  = 16'd2;
  localparam logic [15:0] BITS_8       = 16'd8;
  localparam logic [15:0] BITS_16      = 16'd16;

  typedef struct packed {
    status_t     status;
    logic        is_stereo;
    logic        is_sixteen_bit;
    logic [31:0] sample_rate;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } result_t;

endpackage

/* rtl/wavhp_if.sv */
// wavhp_in_if / wavhp_out_if: valid/ready channels for file bytes and
// for the header descriptor. Standalone; no package dependency.
interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

interface wavhp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        is_stereo;
  logic        is_sixteen_bit;
  logic [31:0] sample_rate;
  logic [31:0] payload_offset;
  logic [31:0] payload_length;

  modport source (output valid, output status, output is_stereo, output is_sixteen_bit,
                  output sample_rate, output payload_offset, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input is_stereo, input is_sixteen_bit,
                  input sample_rate, input payload_offset, input payload_length,
                  output ready);
endinterface

/* rtl/wav_header_parser_core.sv */
// wav_header_parser_core: top level of the WAV header parser.
// Depends on wavhp_pkg, wavhp_if, wavhp_parse and wavhp_out_buf.

// Takes a WAV file one byte per beat on in_bus (last_byte marks the final
// byte) and gives one descriptor per file on out_bus: status, stereo and
// 16-bit flags, sample rate, and the offset and length of the data payload.
// Throughput is one byte per clock while in_bus.ready is high: each byte
// passes through a single phase update of the header state machine. The
// descriptor enters the output buffer at the edge that accepts the byte
// that completes it (the data chunk's last length byte, the byte that
// exposes an error, or the final byte of a truncated file). It shows on
// out_bus the next cycle, or once the descriptor ahead of it drains.
// Descriptors queue in a two-entry buffer, so input keeps flowing while a
// descriptor waits; in_bus.ready drops only while both entries are full.
// Bytes after a descriptor are dropped until the final byte, which returns
// the parser to its reset state. Positions count modulo 2^POSITION_WIDTH
// and are zero-extended to 32 bits.
module wav_header_parser_core #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  wavhp_in_if.sink     in_bus,
  wavhp_out_if.source  out_bus
);

  logic               in_beat;
  logic               res_valid;
  wavhp_pkg::result_t res;
  logic               buf_can_push;
  logic               head_valid;
  wavhp_pkg::result_t head;

  assign in_bus.ready = buf_can_push;
  assign in_beat      = in_bus.valid && in_bus.ready;

  // header state machine: one phase update per accepted byte
  wavhp_parse #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (in_beat),
    .in_byte   (in_bus.file_byte),
    .in_last   (in_bus.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold descriptors until the sink takes them
  wavhp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_push   (buf_can_push),
    .head_valid (head_valid),
    .head_data  (head),
    .pop_ready  (out_bus.ready)
  );

  assign out_bus.valid          = head_valid;
  assign out_bus.status         = head.status;
  assign out_bus.is_stereo      = head.is_stereo;
  assign out_bus.is_sixteen_bit = head.is_sixteen_bit;
  assign out_bus.sample_rate    = head.sample_rate;
  assign out_bus.payload_offset = head.payload_offset;
  assign out_bus.payload_length = head.payload_length;

`ifndef ASSERT_OFF
  // a descriptor comes only from an accepted byte
  a_res_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_beat)
    else $error("descriptor produced without an accepted byte");

  // a produced descriptor leaves out_bus valid on the next cycle
  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_bus.valid)
    else $error("descriptor lost in output buffer");

  // input stalls only when a descriptor is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with empty output");

  // a good descriptor always carries a payload
  a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == wavhp_pkg::ST_OK) |-> out_bus.payload_length != 32'd0)
    else $error("ok status with empty payload");
`endif

endmodule

/* rtl/wavhp_parse.sv */
// wavhp_parse: byte-at-a-time RIFF/WAVE header state machine.
// Depends on wavhp_pkg.
module wavhp_parse #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                res_valid,
  output wavhp_pkg::result_t  res
);

  wavhp_pkg::phase_t         phase_r, phase_nxt;
  logic [2:0]                fbc_r, fbc_nxt;
  logic [31:0]               tag_r, tag_nxt;
  logic [31:0]               acc_r, acc_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0]               skip_r, skip_nxt;
  logic [15:0]               fmt_r, fmt_nxt;
  logic [15:0]               chan_r, chan_nxt;
  logic [31:0]               rate_r, rate_nxt;
  logic [15:0]               bits_r, bits_nxt;
  logic                      given_r, given_nxt;

  logic [31:0]               tag_new;
  logic [31:0]               acc_new;
  logic                      done4;
  logic                      done2;
  logic                      emit;
  wavhp_pkg::status_t        st;
  logic [POSITION_WIDTH-1:0] pos_inc;

  always_comb begin
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    tag_nxt   = tag_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    fmt_nxt   = fmt_r;
    chan_nxt  = chan_r;
    rate_nxt  = rate_r;
    bits_nxt  = bits_r;
    given_nxt = given_r;
    emit      = 1'b0;
    st        = wavhp_pkg::ST_OK;
    pos_inc   = pos_r + POSITION_WIDTH'(1);
    tag_new   = {tag_r[23:0], in_byte};
    acc_new   = acc_r | (32'(in_byte) << {fbc_r[1:0], 3'b000});
    done4     = (fbc_r >= 3'd3);
    done2     = (fbc_r >= 3'd1);

    if (beat) begin
      pos_nxt = pos_inc;
      if (!given_r) begin
        case (phase_r)
          wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE: begin
            tag_nxt = tag_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              if (phase_r == wavhp_pkg::PH_RIFF) begin
                if (tag_new != wavhp_pkg::TAG_RIFF) begin
                  emit = 1'b1;
                  st   = wavhp_pkg::ST_NO_RIFF;
                end else begin
                  phase_nxt = wavhp_pkg::PH_SIZE;
                end
              end else begin
                if (tag_new != wavhp_pkg::TAG_WAVE) begin
                  emit = 1'b1;
                  st   = wavhp_pkg::ST_NO_WAVE;
                end else begin
                  phase_nxt = wavhp_pkg::PH_CK_ID;
                end
              end
            end
          end
          wavhp_pkg::PH_SIZE: begin
            acc_nxt = acc_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              acc_nxt   = '0;
              phase_nxt = wavhp_pkg::PH_WAVE;
            end
          end
          wavhp_pkg::PH_CK_ID, wavhp_pkg::PH_DS_ID: begin
            tag_nxt = tag_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              phase_nxt = (phase_r == wavhp_pkg::PH_CK_ID) ? wavhp_pkg::PH_CK_LEN
                                                           : wavhp_pkg::PH_DS_LEN;
            end
          end
          wavhp_pkg::PH_CK_LEN: begin
            acc_nxt = acc_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              acc_nxt = '0;
              if (tag_r == wavhp_pkg::TAG_FMT) begin
                // fmt body beyond the 16 field bytes is skipped afterwards
                skip_nxt  = (acc_new > wavhp_pkg::FMT_BODY_LEN) ?
                            acc_new - wavhp_pkg::FMT_BODY_LEN : '0;
                phase_nxt = wavhp_pkg::PH_FMT_CODE;
              end else if (acc_new == '0) begin
                emit = 1'b1;
                st   = wavhp_pkg::ST_ZERO_CHUNK;
              end else begin
                skip_nxt  = acc_new;
                phase_nxt = wavhp_pkg::PH_CK_SKIP;
              end
            end
          end
          wavhp_pkg::PH_DS_LEN: begin
            acc_nxt = acc_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              acc_nxt = '0;
              if (tag_r == wavhp_pkg::TAG_DATA) begin
                emit = 1'b1;
                st   = (acc_new == '0) ? wavhp_pkg::ST_EMPTY_DATA : wavhp_pkg::ST_OK;
              end else if (acc_new == '0) begin
                emit = 1'b1;
                st   = wavhp_pkg::ST_ZERO_CHUNK;
              end else begin
                skip_nxt  = acc_new;
                phase_nxt = wavhp_pkg::PH_DS_SKIP;
              end
            end
          end
          wavhp_pkg::PH_CK_SKIP, wavhp_pkg::PH_DS_SKIP: begin
            if (skip_r <= 32'd1) begin
              skip_nxt  = '0;
              phase_nxt = (phase_r == wavhp_pkg::PH_CK_SKIP) ? wavhp_pkg::PH_CK_ID
                                                             : wavhp_pkg::PH_DS_ID;
            end else begin
              skip_nxt = skip_r - 32'd1;
            end
          end
          wavhp_pkg::PH_FMT_CODE, wavhp_pkg::PH_FMT_CHAN,
          wavhp_pkg::PH_FMT_ALIGN, wavhp_pkg::PH_FMT_BITS: begin
            acc_nxt = acc_new;
            fbc_nxt = done2 ? 3'd0 : fbc_r + 3'd1;
            if (done2) begin
              acc_nxt = '0;
              case (phase_r)
                wavhp_pkg::PH_FMT_CODE: begin
                  fmt_nxt   = acc_new[15:0];
                  phase_nxt = wavhp_pkg::PH_FMT_CHAN;
                end
                wavhp_pkg::PH_FMT_CHAN: begin
                  chan_nxt  = acc_new[15:0];
                  phase_nxt = wavhp_pkg::PH_FMT_RATE;
                end
                wavhp_pkg::PH_FMT_ALIGN: begin
                  phase_nxt = wavhp_pkg::PH_FMT_BITS;
                end
                default: begin
                  // bit depth closes the field block: validate the format
                  bits_nxt = acc_new[15:0];
                  if (fmt_r != wavhp_pkg::FMT_PCM) begin
                    emit = 1'b1;
                    st   = wavhp_pkg::ST_NOT_PCM;
                  end else if (chan_r != wavhp_pkg::CHAN_MONO &&
                               chan_r != wavhp_pkg::CHAN_STEREO) begin
                    emit = 1'b1;
                    st   = wavhp_pkg::ST_CHANNELS;
                  end else if (acc_new[15:0] != wavhp_pkg::BITS_8 &&
                               acc_new[15:0] != wavhp_pkg::BITS_16) begin
                    emit = 1'b1;
                    st   = wavhp_pkg::ST_BITS;
                  end else begin
                    phase_nxt = (skip_r == '0) ? wavhp_pkg::PH_DS_ID
                                               : wavhp_pkg::PH_DS_SKIP;
                  end
                end
              endcase
            end
          end
          wavhp_pkg::PH_FMT_RATE, wavhp_pkg::PH_FMT_BRATE: begin
            acc_nxt = acc_new;
            fbc_nxt = done4 ? 3'd0 : fbc_r + 3'd1;
            if (done4) begin
              acc_nxt = '0;
              if (phase_r == wavhp_pkg::PH_FMT_RATE) begin
                rate_nxt  = acc_new;
                phase_nxt = wavhp_pkg::PH_FMT_BRATE;
              end else begin
                phase_nxt = wavhp_pkg::PH_FMT_ALIGN;
              end
            end
          end
          default: begin
          end
        endcase

        // file ended before a descriptor: report where it stopped
        if (!emit && in_last) begin
          emit = 1'b1;
          if (phase_nxt == wavhp_pkg::PH_RIFF) begin
            st = wavhp_pkg::ST_NO_RIFF;
          end else if (phase_nxt <= wavhp_pkg::PH_WAVE) begin
            st = wavhp_pkg::ST_NO_WAVE;
          end else if (phase_nxt <= wavhp_pkg::PH_FMT_BITS) begin
            st = wavhp_pkg::ST_NO_FMT;
          end else begin
            st = wavhp_pkg::ST_NO_DATA;
          end
        end
        if (emit) begin
          given_nxt = 1'b1;
        end
      end

      // final byte: back to the start of a new file
      if (in_last) begin
        phase_nxt = wavhp_pkg::PH_RIFF;
        fbc_nxt   = '0;
        tag_nxt   = '0;
        acc_nxt   = '0;
        pos_nxt   = '0;
        skip_nxt  = '0;
        fmt_nxt   = '0;
        chan_nxt  = '0;
        rate_nxt  = '0;
        bits_nxt  = '0;
        given_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    res        = '0;
    res.status = st;
    if (st == wavhp_pkg::ST_OK) begin
      res.is_stereo      = (chan_r == wavhp_pkg::CHAN_STEREO);
      res.is_sixteen_bit = (bits_r == wavhp_pkg::BITS_16);
      res.sample_rate    = rate_r;
      res.payload_offset = 32'(pos_inc);
      res.payload_length = acc_new;
    end
  end

  assign res_valid = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wavhp_pkg::PH_RIFF;
      fbc_r   <= '0;
      tag_r   <= '0;
      acc_r   <= '0;
      pos_r   <= '0;
      skip_r  <= '0;
      fmt_r   <= '0;
      chan_r  <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      given_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      tag_r   <= tag_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      fmt_r   <= fmt_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      given_r <= given_nxt;
    end
  end

endmodule

/* rtl/wavhp_out_buf.sv */
// wavhp_out_buf: two-entry descriptor buffer (output register plus skid).
// Depends on wavhp_pkg.
module wavhp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wavhp_pkg::result_t  push_data,
  output logic                can_push,
  output logic                head_valid,
  output wavhp_pkg::result_t  head_data,
  input  logic                pop_ready
);

  logic               head_valid_r, head_valid_nxt;
  wavhp_pkg::result_t head_r, head_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  wavhp_pkg::result_t skid_r, skid_nxt;
  logic               pop;

  assign pop = head_valid_r && pop_ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // advance the skid entry once the head drains
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!head_valid_r || pop) begin
      head_valid_nxt = push;
      head_nxt       = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push   = !skid_valid_r;
  assign head_valid = head_valid_r;
  assign head_data  = head_r;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives whole and broken WAV files into wav_header_parser_core one byte per
// beat and checks every header descriptor against a local parser model.
// Depends on wavhp_pkg, wavhp_if and the RTL below wav_header_parser_core.
module testbench;

  localparam int POS_W      = 32;
  localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int LONG_HOLD  = 400;   // one long receiver stall to fill the descriptor buffer

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wav_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  wavhp_in_if  in_bus ();
  wavhp_out_if out_bus ();

  wav_header_parser_core #(.POSITION_WIDTH(POS_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // File bytes waiting to be sent, the file under construction, and the
  // descriptors the header model says are still owed by the block.
  wav_beat_t            byte_queue[$];
  logic [7:0]           file_img[$];
  wavhp_pkg::result_t   headers_due[$];
  int unsigned          bytes_taken;
  int unsigned          errors;

  // ---------------------------------------------------------------------
  // Header model: its own copy of the parser state, advanced once per
  // accepted byte.
  // ---------------------------------------------------------------------
  wavhp_pkg::phase_t hp_phase;
  logic [2:0]        hp_count;
  logic [31:0]       hp_tag;
  logic [31:0]       hp_acc;
  logic [POS_W-1:0]  hp_pos;
  logic [31:0]       hp_skip;
  logic [15:0]       hp_format;
  logic [15:0]       hp_chans;
  logic [31:0]       hp_rate;
  logic [15:0]       hp_bits;
  logic              hp_done;

  function automatic void clear_header_state();
    hp_phase  = wavhp_pkg::PH_RIFF;
    hp_count  = '0;
    hp_tag    = '0;
    hp_acc    = '0;
    hp_pos    = '0;
    hp_skip   = '0;
    hp_format = '0;
    hp_chans  = '0;
    hp_rate   = '0;
    hp_bits   = '0;
    hp_done   = 1'b0;
  endfunction

  // Tags arrive big-endian (text order); shift each byte in from the right.
  function automatic logic grab_tag(input logic [7:0] b);
    hp_tag   = {hp_tag[23:0], b};
    hp_count = hp_count + 3'd1;
    if (hp_count >= 3'd4) begin
      hp_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Numeric fields are little-endian.
  function automatic logic grab_field(input logic [7:0] b, input int len);
    hp_acc   = hp_acc | (32'(b) << (8 * hp_count[1:0]));
    hp_count = hp_count + 3'd1;
    if (hp_count >= len) begin
      hp_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Error descriptors carry zeros beside the status.
  function automatic wavhp_pkg::result_t make_header(input wavhp_pkg::status_t st,
                                                     input logic [31:0] off,
                                                     input logic [31:0] len);
    wavhp_pkg::result_t r;
    r = '0;
    r.status = st;
    if (st == wavhp_pkg::ST_OK) begin
      r.is_stereo      = (hp_chans == wavhp_pkg::CHAN_STEREO);
      r.is_sixteen_bit = (hp_bits == wavhp_pkg::BITS_16);
      r.sample_rate    = hp_rate;
      r.payload_offset = off;
      r.payload_length = len;
    end
    return r;
  endfunction

  function automatic logic track_header(input logic [7:0] b, input logic last,
                                        output wavhp_pkg::result_t r);
    logic [POS_W-1:0]    nxt;
    logic [31:0]         v;
    logic                got;
    wavhp_pkg::status_t  st;
    nxt    = hp_pos + 1'b1;
    hp_pos = nxt;
    got    = 1'b0;
    r      = '0;
    if (!hp_done) begin
      case (hp_phase)
        wavhp_pkg::PH_RIFF: begin
          if (grab_tag(b)) begin
            if (hp_tag != wavhp_pkg::TAG_RIFF) begin
              r = make_header(wavhp_pkg::ST_NO_RIFF, '0, '0);
              got = 1'b1;
            end else begin
              hp_phase = wavhp_pkg::PH_SIZE;
            end
          end
        end
        wavhp_pkg::PH_SIZE: begin
          if (grab_field(b, 4)) begin
            hp_acc   = '0;
            hp_phase = wavhp_pkg::PH_WAVE;
          end
        end
        wavhp_pkg::PH_WAVE: begin
          if (grab_tag(b)) begin
            if (hp_tag != wavhp_pkg::TAG_WAVE) begin
              r = make_header(wavhp_pkg::ST_NO_WAVE, '0, '0);
              got = 1'b1;
            end else begin
              hp_phase = wavhp_pkg::PH_CK_ID;
            end
          end
        end
        wavhp_pkg::PH_CK_ID: begin
          if (grab_tag(b)) hp_phase = wavhp_pkg::PH_CK_LEN;
        end
        wavhp_pkg::PH_DS_ID: begin
          if (grab_tag(b)) hp_phase = wavhp_pkg::PH_DS_LEN;
        end
        wavhp_pkg::PH_CK_LEN: begin
          if (grab_field(b, 4)) begin
            v      = hp_acc;
            hp_acc = '0;
            if (hp_tag == wavhp_pkg::TAG_FMT) begin
              // Only the part of a fmt chunk beyond the 16 field bytes is skipped.
              hp_skip  = (v > wavhp_pkg::FMT_BODY_LEN) ? v - wavhp_pkg::FMT_BODY_LEN : '0;
              hp_phase = wavhp_pkg::PH_FMT_CODE;
            end else if (v == 0) begin
              r = make_header(wavhp_pkg::ST_ZERO_CHUNK, '0, '0);
              got = 1'b1;
            end else begin
              hp_skip  = v;
              hp_phase = wavhp_pkg::PH_CK_SKIP;
            end
          end
        end
        wavhp_pkg::PH_DS_LEN: begin
          if (grab_field(b, 4)) begin
            v      = hp_acc;
            hp_acc = '0;
            got    = 1'b1;
            if (hp_tag == wavhp_pkg::TAG_DATA) begin
              if (v == 0) r = make_header(wavhp_pkg::ST_EMPTY_DATA, '0, '0);
              else r = make_header(wavhp_pkg::ST_OK, 32'(nxt), v);
            end else if (v == 0) begin
              r = make_header(wavhp_pkg::ST_ZERO_CHUNK, '0, '0);
            end else begin
              got      = 1'b0;
              hp_skip  = v;
              hp_phase = wavhp_pkg::PH_DS_SKIP;
            end
          end
        end
        wavhp_pkg::PH_CK_SKIP: begin
          if (hp_skip <= 1) begin
            hp_skip  = '0;
            hp_phase = wavhp_pkg::PH_CK_ID;
          end else begin
            hp_skip = hp_skip - 1;
          end
        end
        wavhp_pkg::PH_DS_SKIP: begin
          if (hp_skip <= 1) begin
            hp_skip  = '0;
            hp_phase = wavhp_pkg::PH_DS_ID;
          end else begin
            hp_skip = hp_skip - 1;
          end
        end
        wavhp_pkg::PH_FMT_CODE: begin
          if (grab_field(b, 2)) begin
            hp_format = hp_acc[15:0];
            hp_acc    = '0;
            hp_phase  = wavhp_pkg::PH_FMT_CHAN;
          end
        end
        wavhp_pkg::PH_FMT_CHAN: begin
          if (grab_field(b, 2)) begin
            hp_chans = hp_acc[15:0];
            hp_acc   = '0;
            hp_phase = wavhp_pkg::PH_FMT_RATE;
          end
        end
        wavhp_pkg::PH_FMT_RATE: begin
          if (grab_field(b, 4)) begin
            hp_rate  = hp_acc;
            hp_acc   = '0;
            hp_phase = wavhp_pkg::PH_FMT_BRATE;
          end
        end
        wavhp_pkg::PH_FMT_BRATE: begin
          if (grab_field(b, 4)) begin
            hp_acc   = '0;
            hp_phase = wavhp_pkg::PH_FMT_ALIGN;
          end
        end
        wavhp_pkg::PH_FMT_ALIGN: begin
          if (grab_field(b, 2)) begin
            hp_acc   = '0;
            hp_phase = wavhp_pkg::PH_FMT_BITS;
          end
        end
        wavhp_pkg::PH_FMT_BITS: begin
          if (grab_field(b, 2)) begin
            hp_bits = hp_acc[15:0];
            hp_acc  = '0;
            got     = 1'b1;
            if (hp_format != wavhp_pkg::FMT_PCM) begin
              r = make_header(wavhp_pkg::ST_NOT_PCM, '0, '0);
            end else if (hp_chans != wavhp_pkg::CHAN_MONO &&
                         hp_chans != wavhp_pkg::CHAN_STEREO) begin
              r = make_header(wavhp_pkg::ST_CHANNELS, '0, '0);
            end else if (hp_bits != wavhp_pkg::BITS_8 &&
                         hp_bits != wavhp_pkg::BITS_16) begin
              r = make_header(wavhp_pkg::ST_BITS, '0, '0);
            end else begin
              got      = 1'b0;
              hp_phase = (hp_skip == 0) ? wavhp_pkg::PH_DS_ID : wavhp_pkg::PH_DS_SKIP;
            end
          end
        end
        default: ;
      endcase
      // A file cut short reports where the parse stood.
      if (!got && last) begin
        if (hp_phase == wavhp_pkg::PH_RIFF) st = wavhp_pkg::ST_NO_RIFF;
        else if (hp_phase <= wavhp_pkg::PH_WAVE) st = wavhp_pkg::ST_NO_WAVE;
        else if (hp_phase <= wavhp_pkg::PH_FMT_BITS) st = wavhp_pkg::ST_NO_FMT;
        else st = wavhp_pkg::ST_NO_DATA;
        r   = make_header(st, '0, '0);
        got = 1'b1;
      end
      if (got) hp_done = 1'b1;
    end
    if (last) clear_header_state();
    return got;
  endfunction

  // ---------------------------------------------------------------------
  // File construction helpers.
  // ---------------------------------------------------------------------
  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_img.push_back(t[8*i +: 8]);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_img.push_back(v[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) file_img.push_back(8'($urandom()));
  endtask

  // Chunks that the parser must step over; now and then a zero length, and
  // now and then a data chunk that shows up early.
  task automatic put_junk_chunks();
    int n, len;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      put_tag(($urandom_range(0, 5) == 0) ? wavhp_pkg::TAG_DATA
                                           : {8'h4C, 24'($urandom())});
      len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      put_le(len, 4);
      put_noise(len);
    end
  endtask

  // Queue the first cut bytes of the file image, marking the final one.
  task automatic ship_file(input int cut);
    wav_beat_t bt;
    for (int i = 0; i < cut; i++) begin
      bt.data = file_img[i];
      bt.last = (i == cut - 1);
      byte_queue.push_back(bt);
    end
    file_img.delete();
  endtask

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int          files, pick, cut, total;
    logic [31:0] fmt_len, data_len, rate;
    rst_n             = 1'b0;
    bytes_taken       = 0;
    errors            = 0;
    files             = 0;
    clear_header_state();

    // Directed: a one-byte file, a wrong RIFF tag followed by bytes that
    // must be dropped, and a file cut off inside the WAVE tag.
    put_tag(wavhp_pkg::TAG_RIFF);
    ship_file(1);
    put_tag(wavhp_pkg::TAG_RIFF ^ 32'h1);
    put_le(32'h0000_FF00, 2);
    ship_file(6);
    put_tag(wavhp_pkg::TAG_RIFF);
    put_le(32'h0, 4);
    put_tag(wavhp_pkg::TAG_WAVE);
    ship_file(11);
    files = 3;

    // Random files: mostly well-formed headers with random content, some
    // with a broken tag or field, some cut short, a few pure noise.
    while (byte_queue.size() < 1450 || files < 50) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        put_noise($urandom_range(1, 12));
      end else begin
        put_tag(($urandom_range(0, 19) == 0) ? $urandom() : wavhp_pkg::TAG_RIFF);
        put_le($urandom(), 4);
        put_tag(($urandom_range(0, 19) == 0) ? $urandom() : wavhp_pkg::TAG_WAVE);
        put_junk_chunks();
        if ($urandom_range(0, 29) != 0) begin
          put_tag(wavhp_pkg::TAG_FMT);
          pick = $urandom_range(0, 99);
          fmt_len = (pick < 70) ? 16 : (pick < 85) ? $urandom_range(17, 22)
                                                   : $urandom_range(0, 15);
          put_le(fmt_len, 4);
          put_le(($urandom_range(0, 9) == 0) ? $urandom() : wavhp_pkg::FMT_PCM, 2);
          pick = $urandom_range(0, 9);
          put_le((pick < 5) ? wavhp_pkg::CHAN_MONO
                 : (pick < 9) ? wavhp_pkg::CHAN_STEREO : $urandom(), 2);
          case ($urandom_range(0, 5))
            0: rate = 32'd8000;
            1: rate = 32'd44100;
            2: rate = 32'd0;
            3: rate = 32'hFFFF_FFFF;
            default: rate = $urandom();
          endcase
          put_le(rate, 4);
          put_le($urandom(), 4);
          put_le($urandom(), 2);
          pick = $urandom_range(0, 9);
          put_le((pick < 5) ? wavhp_pkg::BITS_8
                 : (pick < 9) ? wavhp_pkg::BITS_16 : $urandom(), 2);
          if (fmt_len > 16) put_noise(fmt_len - 16);
        end
        put_junk_chunks();
        if ($urandom_range(0, 24) != 0) begin
          put_tag(wavhp_pkg::TAG_DATA);
          pick = $urandom_range(0, 99);
          data_len = (pick < 8) ? 0 : (pick < 18) ? $urandom()
                   : (pick < 26) ? 32'hFFFF_FFFF : $urandom_range(1, 8);
          put_le(data_len, 4);
          put_noise((data_len <= 6) ? data_len : $urandom_range(0, 6));
        end else begin
          put_noise($urandom_range(1, 8));
        end
      end
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, file_img.size())
                                        : file_img.size();
      ship_file(cut);
      files++;
    end
    total = byte_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every byte is in and every owed descriptor has arrived,
    // then keep running so that any stray descriptor can still show.
    while (bytes_taken < total || headers_due.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Byte driver: one beat at a time from byte_queue, with a drawn idle gap
  // after each beat, and runs with no gaps at all.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    wav_beat_t bt;
    int        send_gap;
    logic      send_steady;
    if (!rst_n) begin
      in_bus.valid     <= 1'b0;
      in_bus.file_byte <= '0;
      in_bus.last_byte <= 1'b0;
      send_gap    = 0;
      send_steady = 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      // The slot is free: either idle out the gap or present the next beat.
      if (send_gap != 0 || byte_queue.size() == 0) begin
        if (send_gap != 0) send_gap--;
        in_bus.valid <= 1'b0;
      end else begin
        bt = byte_queue.pop_front();
        in_bus.file_byte <= bt.data;
        in_bus.last_byte <= bt.last;
        in_bus.valid     <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Descriptor receiver: a drawn stall after each beat, runs with no stall,
  // and one long hold-off so both buffer entries fill and the block has to
  // stall its byte input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : accept_headers
    int   rx_stall;
    int   rx_hold;
    int   rx_count;
    logic rx_steady;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_stall  = 0;
      rx_hold   = 0;
      rx_count  = 0;
      rx_steady = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        rx_count++;
        if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
        rx_stall = rx_steady ? 0 : $urandom_range(0, 3);
        if (rx_count == 12) rx_hold = LONG_HOLD;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_bus.ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t mismatch in %s: expected %0h, actual %0h", $time, what, want, seen);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: advance the header model on every byte beat, and compare
  // every descriptor beat with the oldest one owed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    wavhp_pkg::result_t want;
    logic               got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        got = track_header(in_bus.file_byte, in_bus.last_byte, want);
        if (got) headers_due.push_back(want);
        bytes_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (headers_due.size() == 0) begin
          $display("%0t unexpected descriptor: expected none, actual status %0d",
                   $time, out_bus.status);
          errors++;
        end else begin
          want = headers_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_bus.status));
          check_field("is_stereo", 32'(want.is_stereo), 32'(out_bus.is_stereo));
          check_field("is_sixteen_bit", 32'(want.is_sixteen_bit),
                      32'(out_bus.is_sixteen_bit));
          check_field("sample_rate", want.sample_rate, out_bus.sample_rate);
          check_field("payload_offset", want.payload_offset, out_bus.payload_offset);
          check_field("payload_length", want.payload_length, out_bus.payload_length);
        end
      end
    end
  end

  // Watchdog: drop the run if neither side moves a beat for too long.
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
